/* design/acip_pkg.sv */
// shared types, codes and widths of the anchor curve interpolator
package acip_pkg;

  localparam int POS_W = 31;
  localparam int VAL_W = 32;
  localparam int MODE_W = 2;
  localparam int OP_W = 2;
  localparam int STAT_W = 2;
  localparam int QPOS_W = 47;

  localparam int DEF_MAX_ANCHORS = 256;
  localparam int DEF_FRAC_BITS = 16;

  localparam int T_BITS = 30;
  localparam int QUO_W = 34;
  localparam int LIMB_W = 32;
  localparam int FACT_W = 33;
  localparam int WIDE_W = 160;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HERMITE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
  } anchor_t;

endpackage

/* design/anchor_curve_interpolator_top.sv */
// top level: anchor table in ram, walk pointer and interpolation sequencer
//
// channel   direction  handshake              payload
// command   in         start & !busy          opcode, anchor_position, anchor_value,
//                                             anchor_mode, query_position, batch_start
// result    out        done (one cycle)       curve_value, value_valid, status
//
// clear, append and unused opcodes finish in the idle state; the result beat follows next cycle
// a query checks the anchor before the pointer when the pointer is off the table start,
// then walks on with one ram read per anchor it steps over
// linear adds the 34-step division that forms t
// hermite adds on top of that, per inner tangent, eight limb multiplies and one
// 34-step division, all on shared units
// reset is synchronous and empties the table; the ram itself is never cleared
// results cannot be held off: each beat is on the ports for exactly one cycle
module anchor_curve_interpolator_top #(
  parameter int MAX_ANCHORS = acip_pkg::DEF_MAX_ANCHORS,
  parameter int FRAC_BITS = acip_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [acip_pkg::OP_W-1:0]           opcode,
  input  logic [acip_pkg::POS_W-1:0]          anchor_position,
  input  logic signed [acip_pkg::VAL_W-1:0]   anchor_value,
  input  logic [acip_pkg::MODE_W-1:0]         anchor_mode,
  input  logic [acip_pkg::QPOS_W-1:0]         query_position,
  input  logic                                batch_start,
  output logic                                done,
  output logic signed [acip_pkg::VAL_W-1:0]   curve_value,
  output logic                                value_valid,
  output logic [acip_pkg::STAT_W-1:0]         status
);
  import acip_pkg::*;

  localparam int AW = $clog2(MAX_ANCHORS);
  localparam int CNTW = $clog2(MAX_ANCHORS + 1);
  localparam int PW = POS_W + FRAC_BITS;
  localparam int CW = (PW > QPOS_W) ? PW : QPOS_W;
  localparam int DW = VAL_W + 1;
  localparam int MW = QUO_W + 1;

  // sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BACK  = 5'd1;
  localparam logic [4:0] S_BACKD = 5'd2;
  localparam logic [4:0] S_WALK  = 5'd3;
  localparam logic [4:0] S_WALKD = 5'd4;
  localparam logic [4:0] S_SEL   = 5'd5;
  localparam logic [4:0] S_LEFT  = 5'd6;
  localparam logic [4:0] S_TDIV  = 5'd7;
  localparam logic [4:0] S_TDIVW = 5'd8;
  localparam logic [4:0] S_N0    = 5'd9;
  localparam logic [4:0] S_N0D   = 5'd10;
  localparam logic [4:0] S_N3    = 5'd11;
  localparam logic [4:0] S_N3D   = 5'd12;
  localparam logic [4:0] S_TAN   = 5'd13;
  localparam logic [4:0] S_TANW  = 5'd14;
  localparam logic [4:0] S_TDV   = 5'd15;
  localparam logic [4:0] S_T2    = 5'd16;
  localparam logic [4:0] S_T3    = 5'd17;
  localparam logic [4:0] S_H     = 5'd18;
  localparam logic [4:0] S_A0    = 5'd19;
  localparam logic [4:0] S_A1    = 5'd20;
  localparam logic [4:0] S_A2    = 5'd21;
  localparam logic [4:0] S_LIN   = 5'd22;
  localparam logic [4:0] S_FIN   = 5'd23;

  // tangent micro-steps: two denominator products, numerator, then divide
  localparam logic [3:0] TS_D1_HL = 4'd0;
  localparam logic [3:0] TS_D1_B  = 4'd1;
  localparam logic [3:0] TS_D2_HR = 4'd2;
  localparam logic [3:0] TS_D2_A  = 4'd3;
  localparam logic [3:0] TS_N_3   = 4'd4;
  localparam logic [3:0] TS_N_H   = 4'd5;
  localparam logic [3:0] TS_N_A   = 4'd6;
  localparam logic [3:0] TS_N_B   = 4'd7;
  localparam logic [3:0] TS_DIV   = 4'd8;

  logic [4:0] state;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] walk;
  logic [POS_W-1:0] last_pos;
  logic [QPOS_W-1:0] q;

  // segment registers
  logic [POS_W-1:0] x1, x2, w;
  logic signed [VAL_W-1:0] y1, y2;
  logic signed [DW-1:0] dy;
  logic [MODE_W-1:0] mode;

  // tangent operands
  logic [POS_W-1:0] th_l, th_r;
  logic signed [DW-1:0] tdl, tdr;
  logic which;
  logic [3:0] tstep;
  logic [WIDE_W-1:0] xw, dw;

  // hermite terms
  logic [T_BITS-1:0] t, t2, t3;
  logic signed [DW-1:0] h01, h10, h11;
  logic signed [MW-1:0] m1, m2;
  logic signed [63:0] acc;

  // ram
  anchor_t rd;
  anchor_t wr;
  logic [$bits(anchor_t)-1:0] rd_bits;
  logic ram_we;
  logic [CNTW-1:0] ra_full;
  logic [CW-1:0] rd_posq, q_ext, x2q;

  // shared units
  logic mul_start, mul_done, div_start, div_done;
  logic [WIDE_W-1:0] mul_a, mul_p, div_num, div_den;
  logic [FACT_W-1:0] mul_f;
  logic [QUO_W-1:0] div_quo;

  logic tzero;
  logic [DW-1:0] dl_neg, dr_neg;
  logic [VAL_W-1:0] a_mag, b_mag;
  logic [CW-1:0] dq;
  logic signed [MW-1:0] m_mag, m_val;

  logic [T_BITS-1:0] tm_a, tm_b;
  logic [2*T_BITS-1:0] tsq;
  logic signed [DW-1:0] hsel;
  logic signed [MW-1:0] msel;
  logic signed [DW+MW-1:0] hm_prod;
  logic signed [DW-1:0] ts, t2s, t3s;

  logic signed [63:0] rnd, shd;
  logic signed [35:0] vsum;
  logic signed [VAL_W-1:0] vsat;

  logic [STAT_W-1:0] app_stat;
  logic [CNTW-1:0] w0;

  assign busy = (state != S_IDLE);
  assign rd = anchor_t'(rd_bits);

  assign rd_posq = CW'(rd.pos) << FRAC_BITS;
  assign x2q = CW'(x2) << FRAC_BITS;
  assign q_ext = CW'(q);

  // append check: full first, then ordering against the last anchor
  always_comb begin
    if (count >= CNTW'(MAX_ANCHORS)) begin
      app_stat = ST_FULL;
    end else if (count != '0 && anchor_position <= last_pos) begin
      app_stat = ST_ORDER;
    end else begin
      app_stat = ST_OK;
    end
  end

  assign w0 = (batch_start || walk > count) ? '0 : walk;

  assign ram_we = start && !busy && (opcode == OP_APPEND) && (app_stat == ST_OK);
  assign wr = '{mode: anchor_mode, value: anchor_value, pos: anchor_position};

  always_comb begin
    unique case (state)
      S_BACK, S_SEL: ra_full = walk - CNTW'(1);
      S_N0:          ra_full = walk - CNTW'(2);
      S_N3:          ra_full = walk + CNTW'(1);
      default:       ra_full = walk;
    endcase
  end

  acip_ram #(
    .WIDTH($bits(anchor_t)),
    .DEPTH(MAX_ANCHORS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[AW-1:0]),
    .wdata(wr),
    .raddr(ra_full[AW-1:0]),
    .rdata(rd_bits)
  );

  // tangent operand magnitudes and the zero case
  assign tzero = (tdl == '0) || (tdr == '0) || (tdl[DW-1] != tdr[DW-1]);
  assign dl_neg = -tdl;
  assign dr_neg = -tdr;
  assign a_mag = tdl[DW-1] ? dl_neg[VAL_W-1:0] : tdl[VAL_W-1:0];
  assign b_mag = tdr[DW-1] ? dr_neg[VAL_W-1:0] : tdr[VAL_W-1:0];

  always_comb begin
    mul_a = xw;
    mul_f = '0;
    unique case (tstep)
      TS_D1_HL: begin
        mul_a = WIDE_W'({th_r, 1'b0}) + WIDE_W'(th_l);
        mul_f = FACT_W'(th_l);
      end
      TS_D1_B:  mul_f = FACT_W'(b_mag);
      TS_D2_HR: begin
        mul_a = WIDE_W'({th_l, 1'b0}) + WIDE_W'(th_r);
        mul_f = FACT_W'(th_r);
      end
      TS_D2_A:  mul_f = FACT_W'(a_mag);
      TS_N_3: begin
        mul_a = WIDE_W'(w);
        mul_f = FACT_W'(3);
      end
      TS_N_H:   mul_f = FACT_W'(th_l) + FACT_W'(th_r);
      TS_N_A:   mul_f = FACT_W'(a_mag);
      TS_N_B:   mul_f = FACT_W'(b_mag);
      default:  mul_f = '0;
    endcase
  end

  assign mul_start = (state == S_TAN) && (tstep != TS_DIV) && !(tstep == TS_D1_HL && tzero);

  // t = (q - x1) / w as Q0.30, or the tangent quotient
  assign dq = q_ext - (CW'(x1) << FRAC_BITS);
  assign div_start = (state == S_TDIV) || (state == S_TAN && tstep == TS_DIV);
  assign div_num = (state == S_TDIV) ? (WIDE_W'(dq) << T_BITS) : xw;
  assign div_den = (state == S_TDIV) ? WIDE_W'(CW'(w) << FRAC_BITS) : dw;

  acip_mul #(
    .NW(WIDE_W),
    .FW(FACT_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a_in (mul_a),
    .f_in (mul_f),
    .done (mul_done),
    .p    (mul_p)
  );

  acip_div #(
    .NW(WIDE_W),
    .QB(QUO_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign m_mag = $signed({1'b0, div_quo});
  assign m_val = tdl[DW-1] ? -m_mag : m_mag;

  // powers of t
  assign tm_a = (state == S_T3) ? t2 : t;
  assign tm_b = t;
  assign tsq = tm_a * tm_b;

  assign ts = $signed(DW'(t));
  assign t2s = $signed(DW'(t2));
  assign t3s = $signed(DW'(t3));

  // basis times slope, one product per cycle
  always_comb begin
    unique case (state)
      S_A0: begin
        hsel = h01;
        msel = MW'(dy);
      end
      S_A1: begin
        hsel = h10;
        msel = m1;
      end
      S_A2: begin
        hsel = h11;
        msel = m2;
      end
      default: begin
        hsel = ts;
        msel = MW'(dy);
      end
    endcase
  end

  assign hm_prod = hsel * msel;

  // round half up, add the left value, saturate
  assign rnd = acc + (64'sd1 <<< (T_BITS - 1));
  assign shd = rnd >>> T_BITS;
  assign vsum = $signed(shd[35:0]) + 36'(y1);

  always_comb begin
    if (vsum > 36'sd2147483647) begin
      vsat = 32'sh7fffffff;
    end else if (vsum < -36'sd2147483648) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = vsum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      walk <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (opcode)
              OP_CLEAR: begin
                count <= '0;
                walk <= '0;
                done <= 1'b1;
                curve_value <= '0;
                value_valid <= 1'b0;
                status <= ST_OK;
              end
              OP_APPEND: begin
                if (app_stat == ST_OK) begin
                  count <= count + CNTW'(1);
                  last_pos <= anchor_position;
                end
                done <= 1'b1;
                curve_value <= '0;
                value_valid <= 1'b0;
                status <= app_stat;
              end
              OP_QUERY: begin
                q <= query_position;
                walk <= w0;
                state <= S_BACK;
              end
              default: begin
                done <= 1'b1;
                curve_value <= '0;
                value_valid <= 1'b0;
                status <= ST_OK;
              end
            endcase
          end
        end
        S_BACK: begin
          state <= (walk == '0) ? S_WALK : S_BACKD;
        end
        S_BACKD: begin
          // query at or below the anchor before the pointer restarts the walk
          if (rd_posq >= q_ext) begin
            walk <= '0;
          end
          state <= S_WALK;
        end
        S_WALK: begin
          state <= (walk < count) ? S_WALKD : S_SEL;
        end
        S_WALKD: begin
          x2 <= rd.pos;
          y2 <= rd.value;
          if (rd_posq < q_ext) begin
            walk <= walk + CNTW'(1);
            state <= S_WALK;
          end else begin
            state <= S_SEL;
          end
        end
        S_SEL: begin
          if (walk < count && x2q == q_ext) begin
            done <= 1'b1;
            curve_value <= y2;
            value_valid <= 1'b1;
            status <= ST_OK;
            state <= S_IDLE;
          end else if (walk == '0 || walk >= count) begin
            done <= 1'b1;
            curve_value <= '0;
            value_valid <= 1'b0;
            status <= ST_OK;
            state <= S_IDLE;
          end else begin
            state <= S_LEFT;
          end
        end
        S_LEFT: begin
          x1 <= rd.pos;
          y1 <= rd.value;
          mode <= rd.mode;
          w <= x2 - rd.pos;
          dy <= DW'(y2) - DW'(rd.value);
          if (rd.mode != MODE_LINEAR && rd.mode != MODE_HERMITE) begin
            done <= 1'b1;
            curve_value <= '0;
            value_valid <= 1'b0;
            status <= ST_OK;
            state <= S_IDLE;
          end else begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          state <= S_TDIVW;
        end
        S_TDIVW: begin
          if (div_done) begin
            t <= div_quo[T_BITS-1:0];
            state <= (mode == MODE_LINEAR) ? S_LIN : S_N0;
          end
        end
        S_N0: begin
          // first segment of the table takes the secant as its left tangent
          if (walk >= CNTW'(2)) begin
            state <= S_N0D;
          end else begin
            m1 <= MW'(dy);
            state <= S_N3;
          end
        end
        S_N0D: begin
          th_l <= x1 - rd.pos;
          th_r <= w;
          tdl <= DW'(y1) - DW'(rd.value);
          tdr <= dy;
          which <= 1'b0;
          tstep <= TS_D1_HL;
          state <= S_TAN;
        end
        S_N3: begin
          if (walk + CNTW'(1) < count) begin
            state <= S_N3D;
          end else begin
            m2 <= MW'(dy);
            state <= S_T2;
          end
        end
        S_N3D: begin
          th_l <= w;
          th_r <= rd.pos - x2;
          tdl <= dy;
          tdr <= DW'(rd.value) - DW'(y2);
          which <= 1'b1;
          tstep <= TS_D1_HL;
          state <= S_TAN;
        end
        S_TAN: begin
          if (tstep == TS_D1_HL && tzero) begin
            // slopes change sign or one is flat: tangent is zero
            if (which) begin
              m2 <= '0;
              state <= S_T2;
            end else begin
              m1 <= '0;
              state <= S_N3;
            end
          end else if (tstep == TS_DIV) begin
            state <= S_TDV;
          end else begin
            if (tstep == TS_D2_HR) begin
              dw <= xw;
            end else if (tstep == TS_N_3) begin
              dw <= dw + xw;
            end
            state <= S_TANW;
          end
        end
        S_TANW: begin
          if (mul_done) begin
            xw <= mul_p;
            tstep <= tstep + 4'd1;
            state <= S_TAN;
          end
        end
        S_TDV: begin
          if (div_done) begin
            if (which) begin
              m2 <= m_val;
              state <= S_T2;
            end else begin
              m1 <= m_val;
              state <= S_N3;
            end
          end
        end
        S_T2: begin
          t2 <= tsq[2*T_BITS-1:T_BITS];
          state <= S_T3;
        end
        S_T3: begin
          t3 <= tsq[2*T_BITS-1:T_BITS];
          state <= S_H;
        end
        S_H: begin
          h01 <= 33'sd3 * t2s - 33'sd2 * t3s;
          h10 <= t3s - 33'sd2 * t2s + ts;
          h11 <= t3s - t2s;
          state <= S_A0;
        end
        S_A0: begin
          acc <= $signed(hm_prod[63:0]);
          state <= S_A1;
        end
        S_A1: begin
          acc <= acc + $signed(hm_prod[63:0]);
          state <= S_A2;
        end
        S_A2: begin
          acc <= acc + $signed(hm_prod[63:0]);
          state <= S_FIN;
        end
        S_LIN: begin
          acc <= $signed(hm_prod[63:0]);
          state <= S_FIN;
        end
        S_FIN: begin
          done <= 1'b1;
          curve_value <= vsat;
          value_valid <= 1'b1;
          status <= ST_OK;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/acip_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module acip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/acip_mul.sv */
// wide by narrow multiplier, one limb per cycle, product kept modulo the wide width
module acip_mul #(
  parameter int NW = acip_pkg::WIDE_W,
  parameter int FW = acip_pkg::FACT_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] a_in,
  input  logic [FW-1:0] f_in,
  output logic          done,
  output logic [NW-1:0] p
);
  import acip_pkg::*;

  localparam int NL = NW / LIMB_W;
  localparam int CNT_W = (NL > 1) ? $clog2(NL) : 1;
  localparam int S_W = LIMB_W + FW;

  logic [NW-1:0] a_reg;
  logic [FW-1:0] f_reg;
  logic [FW-1:0] carry;
  logic [CNT_W-1:0] cnt;
  logic run;
  logic [S_W-1:0] s;

  // one limb times the factor plus the running carry
  assign s = S_W'(a_reg[LIMB_W-1:0]) * S_W'(f_reg) + S_W'(carry);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      a_reg <= a_in;
      f_reg <= f_in;
      carry <= '0;
      p <= '0;
      cnt <= CNT_W'(NL - 1);
      run <= 1'b1;
    end else if (run) begin
      p <= {s[LIMB_W-1:0], p[NW-1:LIMB_W]};
      a_reg <= a_reg >> LIMB_W;
      carry <= s[S_W-1:LIMB_W];
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

/* design/acip_div.sv */
// restoring divider, one quotient bit per cycle, quotient known to fit QB bits
module acip_div #(
  parameter int NW = acip_pkg::WIDE_W,
  parameter int QB = acip_pkg::QUO_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [NW-1:0] den,
  output logic          done,
  output logic [QB-1:0] quo
);

  localparam int CNT_W = $clog2(QB);

  logic [NW-1:0] r;
  logic [NW-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic run;
  logic ge;

  assign ge = (r >= d);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      r <= num;
      d <= den << (QB - 1);
      quo <= '0;
      cnt <= CNT_W'(QB - 1);
      run <= 1'b1;
    end else if (run) begin
      if (ge) begin
        r <= r - d;
      end
      quo <= {quo[QB-2:0], ge};
      d <= d >> 1;
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        run <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

/* design/acip_check.sv */
// port-level checks on the anchor curve interpolator, bound to the top level
module acip_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [acip_pkg::OP_W-1:0]         opcode,
  input logic                              done,
  input logic signed [acip_pkg::VAL_W-1:0] curve_value,
  input logic                              value_valid,
  input logic [acip_pkg::STAT_W-1:0]       status
);
  import acip_pkg::*;

  // table commands finish with a result beat in the next cycle and leave the block free
  a_cmd_fast: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode != OP_QUERY |=> done && !busy)
    else $error("table command did not finish in one cycle");

  // no beat without an accepted command or a query in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result beat with nothing in flight");

  // a finishing query delivers its beat as the block frees up
  a_query_end: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("query finished without a result beat");

  // no value means a zero value
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    done && !value_valid |-> curve_value == '0)
    else $error("nonzero value on an invalid result");

  // append errors never carry a value
  a_status_novalue: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> !value_valid)
    else $error("value returned together with an error status");

endmodule

bind anchor_curve_interpolator_top acip_check u_acip_check (.*);
